### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define KEFUF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, sampled on clk, quiet during rst
`define KEFUF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### sv/kefuf_pkg.sv
`default_nettype none

package kefuf_pkg;

  // graph size and field widths
  localparam int NODES       = 1024;
  localparam int NODE_W      = (NODES > 2) ? $clog2(NODES) : 1;
  localparam int PORT_NODE_W = 10;
  localparam int WEIGHT_W    = 32;
  localparam int SUM_W       = 48;
  localparam int RANK_W      = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_CLR_STEP,
    OP_FIND_A,
    OP_COMP_A,
    OP_FIND_B,
    OP_COMP_B,
    OP_RANK_A,
    OP_UNION,
    OP_EMIT
  } dp_op_t;

  // datapath status returned to the controller
  typedef struct packed {
    logic in_range;
    logic found;
    logic done_a;
    logic done_b;
    logic roots_eq;
    logic clr_last;
  } dp_status_t;

endpackage

`default_nettype wire

### sv/kruskal_edge_filter_union_find.sv
`default_nettype none

// Union-find edge filter for a Kruskal spanning tree: feed edges in weight order; each edge
// transaction returns one result saying whether the edge joined two sets, the root of the
// merged set (or of node_a when both already share a set, zero when a node is out of range) and
// the saturating total of accepted weights. Items are handled one at a time. An edge walks
// the parent hops from node_a and node_b to their roots on the single read port of the parent
// memory, once to find each root and once to relink the path. A clear command (command = 0)
// and reset both run a clearing pass over all 1024 memory entries, one entry per cycle,
// during which no transaction is taken; a clear then returns an all-zero result.

module kruskal_edge_filter_union_find (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 command,
  input  wire [kefuf_pkg::PORT_NODE_W-1:0]    node_a,
  input  wire [kefuf_pkg::PORT_NODE_W-1:0]    node_b,
  input  wire [kefuf_pkg::WEIGHT_W-1:0]       edge_weight,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic                                accepted,
  output logic [kefuf_pkg::PORT_NODE_W-1:0]   merged_root,
  output logic [kefuf_pkg::SUM_W-1:0]         tree_length
);
  import kefuf_pkg::*;

  dp_op_t     op;
  dp_status_t st;

  // sequencer
  kefuf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .st        (st)
  );

  // memories, root search and union arithmetic
  kefuf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .st          (st),
    .node_a      (node_a),
    .node_b      (node_b),
    .edge_weight (edge_weight),
    .accepted    (accepted),
    .merged_root (merged_root),
    .tree_length (tree_length)
  );

endmodule

`default_nettype wire

### sv/kefuf_dp.sv
`default_nettype none

module kefuf_dp (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire kefuf_pkg::dp_op_t                 op,
  output kefuf_pkg::dp_status_t                  st,
  input  wire [kefuf_pkg::PORT_NODE_W-1:0]       node_a,
  input  wire [kefuf_pkg::PORT_NODE_W-1:0]       node_b,
  input  wire [kefuf_pkg::WEIGHT_W-1:0]          edge_weight,
  output logic                                   accepted,
  output logic [kefuf_pkg::PORT_NODE_W-1:0]      merged_root,
  output logic [kefuf_pkg::SUM_W-1:0]            tree_length
);
  import kefuf_pkg::*;
  `include "assert_macros.svh"

  // parent and rank memories
  logic [NODE_W-1:0] parent_mem [NODES];
  logic [RANK_W-1:0] rank_mem   [NODES];

  logic              par_we;
  logic [NODE_W-1:0] par_waddr;
  logic [NODE_W-1:0] par_wdata;
  logic [NODE_W-1:0] par_raddr;
  logic [NODE_W-1:0] par_rdata;
  logic              rank_we;
  logic [NODE_W-1:0] rank_waddr;
  logic [RANK_W-1:0] rank_wdata;
  logic [NODE_W-1:0] rank_raddr;
  logic [RANK_W-1:0] rank_rdata;

  // working registers
  logic [NODE_W-1:0]   node_a_q;
  logic [NODE_W-1:0]   node_b_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [NODE_W-1:0]   cur;
  logic [NODE_W-1:0]   walk;
  logic [NODE_W-1:0]   ra;
  logic [NODE_W-1:0]   rb;
  logic [RANK_W-1:0]   rank_a;
  logic [SUM_W-1:0]    length_sum;
  logic [NODE_W-1:0]   clr_cnt;
  logic                res_acc;
  logic [NODE_W-1:0]   res_root;

  logic [NODE_W-1:0] node_a_n;
  logic [NODE_W-1:0] node_b_n;
  logic              b_wins;
  logic [NODE_W-1:0] win;
  logic [NODE_W-1:0] lose;
  logic              rank_bump;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;

  assign node_a_n = NODE_W'(node_a);
  assign node_b_n = NODE_W'(node_b);

  // status towards the controller
  assign st.in_range = (32'(node_a) < NODES) && (32'(node_b) < NODES);
  assign st.found    = (par_rdata == cur);
  assign st.done_a   = (walk == ra);
  assign st.done_b   = (walk == rb);
  assign st.roots_eq = (ra == rb);
  assign st.clr_last = (clr_cnt == NODE_W'(NODES - 1));

  // union by rank and saturating total
  assign b_wins    = (rank_rdata > rank_a);
  assign win       = b_wins ? rb : ra;
  assign lose      = b_wins ? ra : rb;
  assign rank_bump = (rank_rdata == rank_a) && (rank_a != RANK_MAX);
  assign sum_ext   = {1'b0, length_sum} + (SUM_W + 1)'(weight_q);
  assign sum_sat   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  // memory address and write selection
  always_comb begin
    par_we     = 1'b0;
    par_waddr  = walk;
    par_wdata  = ra;
    par_raddr  = node_a_n;
    rank_we    = 1'b0;
    rank_waddr = clr_cnt;
    rank_wdata = '0;
    rank_raddr = ra;
    unique case (op)
      OP_CLR_STEP: begin
        par_we    = 1'b1;
        par_waddr = clr_cnt;
        par_wdata = clr_cnt;
        rank_we   = 1'b1;
      end
      OP_FIND_A: begin
        par_raddr = st.found ? node_a_q : par_rdata;
      end
      OP_FIND_B: begin
        par_raddr = st.found ? node_b_q : par_rdata;
      end
      OP_COMP_A: begin
        if (st.done_a) begin
          par_raddr = node_b_q;
        end else begin
          par_we    = 1'b1;
          par_wdata = ra;
          par_raddr = par_rdata;
        end
      end
      OP_COMP_B: begin
        if (!st.done_b) begin
          par_we    = 1'b1;
          par_wdata = rb;
          par_raddr = par_rdata;
        end
      end
      OP_RANK_A: begin
        rank_raddr = rb;
      end
      OP_UNION: begin
        par_we     = 1'b1;
        par_waddr  = lose;
        par_wdata  = win;
        rank_we    = rank_bump;
        rank_waddr = ra;
        rank_wdata = rank_a + RANK_W'(1);
      end
      default: begin
      end
    endcase
  end

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    par_rdata <= parent_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata <= rank_mem[rank_raddr];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (op == OP_CLR_STEP) begin
      clr_cnt <= st.clr_last ? '0 : clr_cnt + NODE_W'(1);
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        node_a_q <= node_a_n;
        node_b_q <= node_b_n;
        weight_q <= edge_weight;
        cur      <= node_a_n;
        res_acc  <= 1'b0;
        res_root <= '0;
      end
      OP_CLR_STEP: begin
        if (st.clr_last) begin
          length_sum <= '0;
        end
      end
      OP_FIND_A: begin
        if (st.found) begin
          ra   <= cur;
          walk <= node_a_q;
        end else begin
          cur <= par_rdata;
        end
      end
      OP_COMP_A: begin
        if (st.done_a) begin
          cur <= node_b_q;
        end else begin
          walk <= par_rdata;
        end
      end
      OP_FIND_B: begin
        if (st.found) begin
          rb   <= cur;
          walk <= node_b_q;
        end else begin
          cur <= par_rdata;
        end
      end
      OP_COMP_B: begin
        if (st.done_b) begin
          res_acc  <= 1'b0;
          res_root <= ra;
        end else begin
          walk <= par_rdata;
        end
      end
      OP_RANK_A: begin
        rank_a <= rank_rdata;
      end
      OP_UNION: begin
        res_acc    <= 1'b1;
        res_root   <= win;
        length_sum <= sum_sat;
      end
      OP_EMIT: begin
        accepted    <= res_acc;
        merged_root <= PORT_NODE_W'(res_root);
        tree_length <= length_sum;
      end
      default: begin
      end
    endcase
  end

  // a union always joins two distinct roots
  `KEFUF_ASSERT_IMP(a_union_distinct, op == OP_UNION, ra != rb)
  // clearing pass wraps back to the first entry
  `KEFUF_ASSERT_NXT(a_clr_wrap, op == OP_CLR_STEP && st.clr_last, clr_cnt == '0)

endmodule

`default_nettype wire

### sv/kefuf_ctrl.sv
`default_nettype none

module kefuf_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    command,
  output logic                   out_valid,
  input  wire                    out_stall,
  output kefuf_pkg::dp_op_t      op,
  input  wire kefuf_pkg::dp_status_t st
);
  import kefuf_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_A,
    S_COMP_A,
    S_FIND_B,
    S_COMP_B,
    S_RANK_A,
    S_UNION,
    S_EMIT
  } state_t;

  state_t state;
  logic   clr_reply;
  logic   emit_go;

  assign in_stall = (state != S_IDLE);
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);

  // operation issued per state
  always_comb begin
    unique case (state)
      S_CLEAR:  op = OP_CLR_STEP;
      S_IDLE:   op = in_valid ? OP_LOAD : OP_IDLE;
      S_FIND_A: op = OP_FIND_A;
      S_COMP_A: op = OP_COMP_A;
      S_FIND_B: op = OP_FIND_B;
      S_COMP_B: op = OP_COMP_B;
      S_RANK_A: op = OP_RANK_A;
      S_UNION:  op = OP_UNION;
      S_EMIT:   op = emit_go ? OP_EMIT : OP_IDLE;
      default:  op = OP_IDLE;
    endcase
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (st.clr_last) begin
            state     <= clr_reply ? S_EMIT : S_IDLE;
            clr_reply <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (!command) begin
              state     <= S_CLEAR;
              clr_reply <= 1'b1;
            end else if (!st.in_range) begin
              state <= S_EMIT;
            end else begin
              state <= S_FIND_A;
            end
          end
        end
        S_FIND_A: begin
          if (st.found) begin
            state <= S_COMP_A;
          end
        end
        S_COMP_A: begin
          if (st.done_a) begin
            state <= S_FIND_B;
          end
        end
        S_FIND_B: begin
          if (st.found) begin
            state <= S_COMP_B;
          end
        end
        S_COMP_B: begin
          if (st.done_b) begin
            state <= st.roots_eq ? S_EMIT : S_RANK_A;
          end
        end
        S_RANK_A: begin
          state <= S_UNION;
        end
        S_UNION: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a clear transaction always starts the clearing pass
  `KEFUF_ASSERT_NXT(a_clear_starts, in_valid && !in_stall && !command, state == S_CLEAR)
  // a result leaving the sequencer shows up on the output
  `KEFUF_ASSERT_NXT(a_emit_shows, emit_go, out_valid && state == S_IDLE)

endmodule

`default_nettype wire
